### rtl/core/sdr_pkg.sv
// Shared types and constants for the signed divide/remainder pipeline.
// No dependencies; used by every module under rtl/core.
package sdr_pkg;

    localparam int DATA_WIDTH = 32;

    // One word in flight through the divider pipeline.
    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] quo;    // dividend bits shift out, quotient bits shift in
        logic [DATA_WIDTH-1:0] rem;    // partial remainder
        logic [DATA_WIDTH-1:0] dvsr;   // divisor magnitude
        logic                  neg_quo;
        logic                  neg_rem;
        logic                  op_rem;
        logic                  div_zero;
    } lane_t;

endpackage

### rtl/core/signed_divide_remainder.sv
// Signed divide/remainder top: operand stage, a row of division cells, output stage.
// Depends on sdr_pkg, sdr_prep, sdr_cell, sdr_fix.

// Pipelined signed divider. One word may be accepted every cycle while no
// finished word is stalled at the output. The magnitudes are registered by
// the operand stage, then one registered cell per quotient bit runs, and the
// output stage applies the sign. The
// quotient truncates toward zero and the remainder carries the dividend's
// sign; the most negative value over minus one wraps to itself. A zero
// divisor sets divide_by_zero and returns all ones as quotient or the
// dividend as remainder. The whole row moves together and holds while a
// finished word is stalled at the output.
module signed_divide_remainder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] dividend,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] divisor,
    input  logic                                  operation,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] result,
    output logic                                  divide_by_zero
);

    logic           advance;
    sdr_pkg::lane_t lane [0:sdr_pkg::DATA_WIDTH];

    assign advance  = ~out_valid | ~out_stall;
    assign in_stall = ~advance;

    sdr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .dividend  (dividend),
        .divisor   (divisor),
        .operation (operation),
        .lane_out  (lane[0])
    );

    for (genvar i = 0; i < sdr_pkg::DATA_WIDTH; i++)
    begin : g_cell
        sdr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    sdr_fix u_fix (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .lane_in        (lane[sdr_pkg::DATA_WIDTH]),
        .out_valid      (out_valid),
        .result         (result),
        .divide_by_zero (divide_by_zero)
    );

endmodule

### rtl/core/sdr_prep.sv
// Operand stage: takes magnitudes and sign decisions, registers the lane.
// Depends on sdr_pkg.
module sdr_prep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] dividend,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] divisor,
    input  logic                                operation,
    output sdr_pkg::lane_t                      lane_out
);

    sdr_pkg::lane_t lane_reg;
    sdr_pkg::lane_t lane_next;
    logic           neg_a;
    logic           neg_b;

    always_comb
    begin
        neg_a = dividend[sdr_pkg::DATA_WIDTH-1];
        neg_b = divisor[sdr_pkg::DATA_WIDTH-1];
        lane_next.valid    = in_valid;
        lane_next.quo      = neg_a ? ('0 - dividend) : dividend;
        lane_next.rem      = '0;
        lane_next.dvsr     = neg_b ? ('0 - divisor) : divisor;
        lane_next.div_zero = (divisor == '0);
        // zero divisor: quotient all ones unsigned, remainder comes back as the dividend
        lane_next.neg_quo  = (neg_a ^ neg_b) & ~lane_next.div_zero;
        lane_next.neg_rem  = neg_a;
        lane_next.op_rem   = operation;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### rtl/core/sdr_cell.sv
// One restoring division step: decides one quotient bit and hands the lane on.
// Depends on sdr_pkg.
module sdr_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  sdr_pkg::lane_t lane_in,
    output sdr_pkg::lane_t lane_out
);

    sdr_pkg::lane_t               lane_reg;
    sdr_pkg::lane_t               lane_next;
    logic [sdr_pkg::DATA_WIDTH:0] shifted;
    logic [sdr_pkg::DATA_WIDTH:0] diff;
    logic                         fits;

    always_comb
    begin
        shifted   = {lane_in.rem, lane_in.quo[sdr_pkg::DATA_WIDTH-1]};
        diff      = shifted - {1'b0, lane_in.dvsr};
        fits      = ~diff[sdr_pkg::DATA_WIDTH];
        lane_next     = lane_in;
        lane_next.quo = {lane_in.quo[sdr_pkg::DATA_WIDTH-2:0], fits};
        lane_next.rem = fits ? diff[sdr_pkg::DATA_WIDTH-1:0]
                             : shifted[sdr_pkg::DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

### rtl/core/sdr_fix.sv
// Output stage: selects quotient or remainder, applies the sign, holds the word.
// Depends on sdr_pkg.
module sdr_fix (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  sdr_pkg::lane_t                        lane_in,
    output logic                                  out_valid,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] result,
    output logic                                  divide_by_zero
);

    logic                          valid_reg;
    logic [sdr_pkg::DATA_WIDTH-1:0] result_reg;
    logic                          dbz_reg;
    logic [sdr_pkg::DATA_WIDTH-1:0] mag;
    logic                          neg;
    logic [sdr_pkg::DATA_WIDTH-1:0] result_next;

    always_comb
    begin
        mag         = lane_in.op_rem ? lane_in.rem : lane_in.quo;
        neg         = lane_in.op_rem ? lane_in.neg_rem : lane_in.neg_quo;
        result_next = neg ? ('0 - mag) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            result_reg <= '0;
            dbz_reg    <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg  <= lane_in.valid;
            result_reg <= result_next;
            dbz_reg    <= lane_in.div_zero;
        end
    end

    assign out_valid      = valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dbz_reg;

endmodule
